/* rtl/core/r250x_pkg.sv */
// Shared constants and types of the R250 XOR generator core.
`timescale 1ns / 1ps

package r250x_pkg;

  localparam int unsigned RING_WORDS = 250;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned LCG_W      = 32;
  localparam int unsigned LCG_OUT_W  = 15;

  localparam logic [LCG_W-1:0]     LCG_MUL     = 32'h015A_4E35;
  localparam logic [WORD_W-1:0]    WORD_MASK   = 16'hFFFF;
  localparam logic [WORD_W-1:0]    HIGH_BIT    = 16'h8000;
  localparam logic [LCG_OUT_W-1:0] HIGH_THRESH = 15'h4000;

  localparam int unsigned LAG_BACK   = 147;
  localparam int unsigned DIAG_START = 3;
  localparam int unsigned DIAG_END   = 179;
  localparam int unsigned DIAG_STEP  = 11;
  localparam int unsigned DIAG_COUNT = (DIAG_END - DIAG_START + DIAG_STEP - 1) / DIAG_STEP;
  localparam int unsigned DIAG_CW    = $clog2(DIAG_COUNT);

  localparam int unsigned MAX_TRIES = 1024;
  localparam int unsigned TRY_W     = $clog2(MAX_TRIES);

  typedef enum logic [1:0] {
    REQ_RESEED  = 2'd0,
    REQ_RAW     = 2'd1,
    REQ_BOUNDED = 2'd2
  } req_e;

  typedef struct packed {
    logic load;
    logic step;
  } lcg_ctrl_t;

endpackage

/* rtl/core/r250x_ring.sv */
// Ring word memory: one write port, two registered read ports.
`timescale 1ns / 1ps

module r250x_ring import r250x_pkg::*; #(
  parameter int unsigned DEPTH = RING_WORDS,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic [AW-1:0]     raddr_a_i,
  input  logic [AW-1:0]     raddr_b_i,
  output logic [WORD_W-1:0] rdata_a_o,
  output logic [WORD_W-1:0] rdata_b_o
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_a_q;
  logic [WORD_W-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

/* rtl/core/r250x_lcg.sv */
// 32-bit linear congruential generator used to fill the ring on reseed.
`timescale 1ns / 1ps

module r250x_lcg import r250x_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lcg_ctrl_t            ctrl_i,
  input  logic [LCG_W-1:0]     seed_i,
  output logic [LCG_OUT_W-1:0] word_o
);

  logic [LCG_W-1:0] state_q;
  logic [LCG_W-1:0] state_d;

  assign state_d = state_q * LCG_MUL + LCG_W'(1);
  // word of the state this step produces
  assign word_o  = state_d[LCG_OUT_W+15:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (ctrl_i.load) begin
      state_q <= seed_i;
    end else if (ctrl_i.step) begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/r250x_div.sv */
// Restoring divider, one quotient bit per cycle, remainder output only.
`timescale 1ns / 1ps

module r250x_div import r250x_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [WORD_W-1:0] dividend_i,
  input  logic [WORD_W-1:0] divisor_i,
  output logic              done_o,
  output logic [WORD_W-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(WORD_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WORD_W - 1);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [WORD_W-1:0] rem_q;
  logic [WORD_W-1:0] rem_d;
  logic [WORD_W-1:0] dvd_q;
  logic [WORD_W-1:0] dsr_q;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   diff;

  always_comb begin
    trial = {rem_q, dvd_q[WORD_W-1]};
    diff  = trial - {1'b0, dsr_q};
    rem_d = (trial >= {1'b0, dsr_q}) ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvd_q  <= '0;
      dsr_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvd_q  <= dividend_i;
      dsr_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[WORD_W-2:0], 1'b0};
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == LAST_STEP) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* rtl/core/r250_xor_random_generator_core.sv */
// Raw draw: ST_DRAW_RD and ST_DRAW_WB, then ST_RESP loads the result word and returns to ST_IDLE.
// Bounded draw: ST_LIMIT divides for the limit, two ring passes per draw pair, ST_MOD for the modulo.
// Reseed: LCG fill of all 250 words, a high bit pass over every word, a diagonal mask on 16 words.
// Each draw is one read of two ring words and one write back in the ring memory.
// Reset clears index, LCG state, seed and control; ring contents stay undefined until a reseed.
`timescale 1ns / 1ps

module r250_xor_random_generator_core import r250x_pkg::*; #(
  parameter int unsigned WORD_COUNT = RING_WORDS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              seed_we_i,
  input  logic [LCG_W-1:0]  seed_wdata_i,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [WORD_W-1:0] s_axis_tdata_i,   // [15:0] draw_bound
  input  logic [1:0]        s_axis_tuser_i,   // [1:0] req_type
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [WORD_W-1:0] m_axis_tdata_o,   // [15:0] value
  output logic [0:0]        m_axis_tuser_o    // [0] error
);

  localparam int unsigned IDX_W = $clog2(WORD_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(WORD_COUNT - 1);
  localparam logic [IDX_W-1:0] LAG_B     = IDX_W'(LAG_BACK);
  localparam logic [IDX_W-1:0] LAG_F     = IDX_W'(WORD_COUNT - LAG_BACK);
  localparam logic [IDX_W-1:0] DIAG_A0   = IDX_W'(DIAG_START);
  localparam logic [IDX_W-1:0] DIAG_INC  = IDX_W'(DIAG_STEP);
  localparam logic [DIAG_CW-1:0] DIAG_LAST = DIAG_CW'(DIAG_COUNT - 1);
  localparam logic [TRY_W-1:0] LAST_TRY  = TRY_W'(MAX_TRIES - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_HIGH_RD,
    ST_HIGH_WB,
    ST_DIAG_RD,
    ST_DIAG_WB,
    ST_LIMIT,
    ST_DRAW_RD,
    ST_DRAW_WB,
    ST_MOD,
    ST_RESP
  } state_e;

  state_e             state_q;
  logic [LCG_W-1:0]   seed_q;
  logic [IDX_W-1:0]   ring_idx_q;
  logic [IDX_W-1:0]   fill_idx_q;
  logic [IDX_W-1:0]   diag_addr_q;
  logic [DIAG_CW-1:0] diag_cnt_q;
  logic               high_q;
  logic               bounded_q;
  logic               second_q;
  logic [TRY_W-1:0]   tries_q;
  logic [WORD_W-1:0]  bound_q;
  logic [WORD_W-1:0]  limit_q;
  logic [WORD_W-1:0]  res_value_q;
  logic               res_error_q;
  logic               out_valid_q;
  logic [WORD_W-1:0]  out_value_q;
  logic               out_error_q;

  logic                 s_accept;
  req_e                 req;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [WORD_W-1:0]    wr_data;
  logic [IDX_W-1:0]     rd_addr_a;
  logic [IDX_W-1:0]     rd_addr_b;
  logic [WORD_W-1:0]    rd_data_a;
  logic [WORD_W-1:0]    rd_data_b;
  logic [WORD_W-1:0]    draw_word;
  lcg_ctrl_t            lcg_ctrl;
  logic [LCG_OUT_W-1:0] lcg_word;
  logic                 div_start;
  logic [WORD_W-1:0]    div_dividend;
  logic [WORD_W-1:0]    div_divisor;
  logic                 div_done;
  logic [WORD_W-1:0]    div_rem;
  logic                 draw_keep;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign req             = req_e'(s_axis_tuser_i);

  // lagged partner of the current ring word
  assign rd_addr_b = (ring_idx_q >= LAG_B) ? ring_idx_q - LAG_B : ring_idx_q + LAG_F;
  assign draw_word = rd_data_a ^ rd_data_b;
  assign draw_keep = draw_word < limit_q;

  r250x_ring #(
    .DEPTH (WORD_COUNT),
    .AW    (IDX_W)
  ) u_ring (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (wr_addr),
    .wdata_i   (wr_data),
    .raddr_a_i (rd_addr_a),
    .raddr_b_i (rd_addr_b),
    .rdata_a_o (rd_data_a),
    .rdata_b_o (rd_data_b)
  );

  r250x_lcg u_lcg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (lcg_ctrl),
    .seed_i (seed_q),
    .word_o (lcg_word)
  );

  r250x_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (seed_we_i) begin
      seed_q <= seed_wdata_i;
    end
  end

  // Every write back lands before the next read is issued, so no forwarding.
  always_comb begin
    wr_en        = 1'b0;
    wr_addr      = ring_idx_q;
    wr_data      = draw_word;
    rd_addr_a    = ring_idx_q;
    lcg_ctrl     = '0;
    div_start    = 1'b0;
    div_dividend = draw_word;
    div_divisor  = bound_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          unique case (req)
            REQ_RESEED: lcg_ctrl.load = 1'b1;
            REQ_BOUNDED: begin
              if (s_axis_tdata_i != '0) begin
                // remainder of the full range sets the rejection limit
                div_start    = 1'b1;
                div_dividend = WORD_MASK;
                div_divisor  = s_axis_tdata_i;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        wr_en         = 1'b1;
        wr_addr       = fill_idx_q;
        wr_data       = {1'b0, lcg_word};
        lcg_ctrl.step = 1'b1;
      end
      ST_HIGH_RD: begin
        rd_addr_a     = fill_idx_q;
        lcg_ctrl.step = 1'b1;
      end
      ST_HIGH_WB: begin
        wr_en   = 1'b1;
        wr_addr = fill_idx_q;
        wr_data = rd_data_a | (high_q ? HIGH_BIT : '0);
      end
      ST_DIAG_RD: rd_addr_a = diag_addr_q;
      ST_DIAG_WB: begin
        wr_en   = 1'b1;
        wr_addr = diag_addr_q;
        wr_data = (rd_data_a & (WORD_MASK >> diag_cnt_q)) | (HIGH_BIT >> diag_cnt_q);
      end
      ST_DRAW_WB: begin
        wr_en     = 1'b1;
        div_start = bounded_q && second_q && draw_keep;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ring_idx_q  <= '0;
      fill_idx_q  <= '0;
      diag_addr_q <= '0;
      diag_cnt_q  <= '0;
      high_q      <= 1'b0;
      bounded_q   <= 1'b0;
      second_q    <= 1'b0;
      tries_q     <= '0;
      bound_q     <= '0;
      limit_q     <= '0;
      res_value_q <= '0;
      res_error_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_error_q <= 1'b0;
    end else begin
      if (m_axis_tready_i && state_q != ST_RESP) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_accept) begin
            unique case (req)
              REQ_RESEED: begin
                ring_idx_q <= '0;
                fill_idx_q <= '0;
                state_q    <= ST_FILL;
              end
              REQ_RAW: begin
                bounded_q <= 1'b0;
                state_q   <= ST_DRAW_RD;
              end
              REQ_BOUNDED: begin
                bound_q   <= s_axis_tdata_i;
                bounded_q <= 1'b1;
                if (s_axis_tdata_i == '0) begin
                  res_value_q <= '0;
                  res_error_q <= 1'b1;
                  state_q     <= ST_RESP;
                end else begin
                  state_q <= ST_LIMIT;
                end
              end
              default: begin
                res_value_q <= '0;
                res_error_q <= 1'b0;
                state_q     <= ST_RESP;
              end
            endcase
          end
        end
        ST_FILL: begin
          if (fill_idx_q == LAST_IDX) begin
            fill_idx_q <= '0;
            state_q    <= ST_HIGH_RD;
          end else begin
            fill_idx_q <= fill_idx_q + IDX_W'(1);
          end
        end
        ST_HIGH_RD: begin
          high_q  <= lcg_word > HIGH_THRESH;
          state_q <= ST_HIGH_WB;
        end
        ST_HIGH_WB: begin
          if (fill_idx_q == LAST_IDX) begin
            diag_addr_q <= DIAG_A0;
            diag_cnt_q  <= '0;
            state_q     <= ST_DIAG_RD;
          end else begin
            fill_idx_q <= fill_idx_q + IDX_W'(1);
            state_q    <= ST_HIGH_RD;
          end
        end
        ST_DIAG_RD: state_q <= ST_DIAG_WB;
        ST_DIAG_WB: begin
          if (diag_cnt_q == DIAG_LAST) begin
            res_value_q <= '0;
            res_error_q <= 1'b0;
            state_q     <= ST_RESP;
          end else begin
            diag_addr_q <= diag_addr_q + DIAG_INC;
            diag_cnt_q  <= diag_cnt_q + DIAG_CW'(1);
            state_q     <= ST_DIAG_RD;
          end
        end
        ST_LIMIT: begin
          if (div_done) begin
            limit_q  <= WORD_MASK - div_rem;
            tries_q  <= '0;
            second_q <= 1'b0;
            state_q  <= ST_DRAW_RD;
          end
        end
        ST_DRAW_RD: state_q <= ST_DRAW_WB;
        ST_DRAW_WB: begin
          ring_idx_q <= (ring_idx_q == LAST_IDX) ? '0 : ring_idx_q + IDX_W'(1);
          if (!bounded_q) begin
            res_value_q <= draw_word;
            res_error_q <= 1'b0;
            state_q     <= ST_RESP;
          end else if (!second_q) begin
            // drop the first draw of the pair
            second_q <= 1'b1;
            state_q  <= ST_DRAW_RD;
          end else if (draw_keep) begin
            state_q <= ST_MOD;
          end else if (tries_q == LAST_TRY) begin
            res_value_q <= '0;
            res_error_q <= 1'b1;
            state_q     <= ST_RESP;
          end else begin
            tries_q  <= tries_q + TRY_W'(1);
            second_q <= 1'b0;
            state_q  <= ST_DRAW_RD;
          end
        end
        ST_MOD: begin
          if (div_done) begin
            res_value_q <= div_rem;
            res_error_q <= 1'b0;
            state_q     <= ST_RESP;
          end
        end
        ST_RESP: begin
          // hold the result until the output register is free
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            out_value_q <= res_value_q;
            out_error_q <= res_error_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_value_q;
  assign m_axis_tuser_o  = out_error_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_idx_q <= LAST_IDX)
    else $error("ring index out of range");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_LIMIT || state_q == ST_MOD))
    else $error("divider finished outside a wait state");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> state_q != ST_IDLE)
    else $error("accepted word did not start work");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_error_q) |-> out_value_q == '0)
    else $error("error result carries a nonzero value");

  a_wr_only_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == ST_FILL || state_q == ST_HIGH_WB ||
               state_q == ST_DIAG_WB || state_q == ST_DRAW_WB))
    else $error("ring written outside a write-back state");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the R250 XOR generator core: directed and random traffic against a predictor.

module tb;
  import r250x_pkg::*;

  localparam logic [1:0]  REQ_UNUSED      = 2'd3;
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned ITEMS_PER_PHASE = 165;
  localparam int unsigned HOLD_AT         = 300;
  localparam int unsigned HOLD_CYCLES     = 400;

  typedef struct packed {
    logic [1:0]        kind;
    logic [WORD_W-1:0] bound;
  } req_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              err;
  } gen_word_t;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              seed_we_i       = 1'b0;
  logic [LCG_W-1:0]  seed_wdata_i    = '0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [WORD_W-1:0] s_axis_tdata_i  = '0;  // [15:0] draw_bound
  logic [1:0]        s_axis_tuser_i  = '0;  // [1:0] req_type
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [WORD_W-1:0] m_axis_tdata_o;        // [15:0] value
  logic [0:0]        m_axis_tuser_o;        // [0] error

  r250_xor_random_generator_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .seed_we_i      (seed_we_i),
    .seed_wdata_i   (seed_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // Generator shadow state
  logic [WORD_W-1:0] ring_copy [RING_WORDS];
  int unsigned       ring_pos  = 0;
  logic [LCG_W-1:0]  lcg_copy  = '0;
  logic [LCG_W-1:0]  seed_copy = '0;

  req_word_t   req_q[$];
  gen_word_t   result_q[$];
  req_word_t   cur_req;
  gen_word_t   got_word;
  gen_word_t   exp_word;
  int unsigned fail_cnt  = 0;
  int unsigned word_cnt  = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  int unsigned hold_left  = 0;
  bit          held       = 1'b0;
  int unsigned mode       = 0;
  int unsigned mode_left  = 0;
  logic [15:0] stall_pat  = 16'hFFFF;

  function automatic logic [LCG_OUT_W-1:0] lcg_advance();
    lcg_copy = lcg_copy * LCG_MUL + 1;
    return lcg_copy[16 +: LCG_OUT_W];
  endfunction

  function automatic void reseed_ring();
    logic [WORD_W-1:0] keep;
    logic [WORD_W-1:0] force_mask;
    keep       = WORD_MASK;
    force_mask = HIGH_BIT;
    lcg_copy   = seed_copy;
    ring_pos   = 0;
    for (int i = 0; i < RING_WORDS; i++) ring_copy[i] = {1'b0, lcg_advance()};
    for (int i = 0; i < RING_WORDS; i++)
      if (lcg_advance() > HIGH_THRESH) ring_copy[i] = ring_copy[i] | HIGH_BIT;
    // diagonal: one forced bit per selected word, walking down from bit 15
    for (int i = DIAG_START; i < DIAG_END; i += DIAG_STEP) begin
      ring_copy[i] = (ring_copy[i] & keep) | force_mask;
      keep       = keep >> 1;
      force_mask = force_mask >> 1;
    end
  endfunction

  function automatic logic [WORD_W-1:0] step_ring();
    int unsigned lag;
    lag = (ring_pos >= LAG_BACK) ? ring_pos - LAG_BACK : ring_pos + (RING_WORDS - LAG_BACK);
    ring_copy[ring_pos] = ring_copy[ring_pos] ^ ring_copy[lag];
    step_ring = ring_copy[ring_pos];
    ring_pos = (ring_pos == RING_WORDS - 1) ? 0 : ring_pos + 1;
  endfunction

  function automatic gen_word_t predict_word(req_word_t rq);
    gen_word_t   r;
    logic [WORD_W-1:0] limit;
    logic [WORD_W-1:0] v;
    r = '0;
    case (rq.kind)
      REQ_RESEED: reseed_ring();
      REQ_RAW:    r.value = step_ring();
      REQ_BOUNDED: begin
        r.err = 1'b1;
        if (rq.bound != 0) begin
          limit = (WORD_MASK / rq.bound) * rq.bound;
          for (int t = 0; t < MAX_TRIES && r.err; t++) begin
            v = step_ring();  // drop the first draw of the pair
            v = step_ring();
            if (v < limit) begin
              r.value = v % rq.bound;
              r.err   = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] pick_bound();
    case ($urandom_range(0, 19))
      0:       return '0;
      1, 2:    return WORD_W'($urandom_range(1, 16));
      3, 4:    return 16'd1 << $urandom_range(0, 15);
      5:       return WORD_W'($urandom_range(65500, 65535));
      6:       return WORD_W'($urandom_range(32768, 32800));
      default: return WORD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic req_word_t pick_req();
    req_word_t   rq;
    int unsigned r;
    r = $urandom_range(0, 99);
    rq.bound = WORD_W'($urandom_range(0, 65535));
    if (r < 2)       rq.kind = REQ_RESEED;
    else if (r < 5)  rq.kind = REQ_UNUSED;
    else if (r < 50) rq.kind = REQ_RAW;
    else begin
      rq.kind  = REQ_BOUNDED;
      rq.bound = pick_bound();
    end
    return rq;
  endfunction

  task automatic push_req(input logic [1:0] kind, input logic [WORD_W-1:0] bound);
    req_word_t rq;
    rq.kind  = kind;
    rq.bound = bound;
    req_q.push_back(rq);
  endtask

  // Wait until every word went in and came out, then let the core settle.
  task automatic drain();
    do @(negedge clk_i);
    while (req_q.size() != 0 || s_axis_tvalid_i || result_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Request driver: bursts of random length with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      s_axis_tuser_i  <= '0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) result_q.push_back(predict_word(cur_req));
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid_i <= 1'b0;
        end else if (req_q.size() > 0) begin
          cur_req = req_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= cur_req.bound;
          s_axis_tuser_i  <= cur_req.kind;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Result sink: changing stall modes plus one long hold-off to back up the core.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (!held && word_cnt >= HOLD_AT) begin
      held      = 1'b1;
      hold_left = HOLD_CYCLES;
      m_axis_tready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
        stall_pat = 16'($urandom_range(1, 65535));
      end else begin
        mode_left--;
      end
      stall_pat = {stall_pat[0], stall_pat[15:1]};
      case (mode)
        0:       m_axis_tready_i <= 1'b1;
        1:       m_axis_tready_i <= 1'($urandom_range(0, 1));
        2:       m_axis_tready_i <= stall_pat[0];
        default: m_axis_tready_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      word_cnt++;
      got_word.value = m_axis_tdata_o;
      got_word.err   = m_axis_tuser_o[0];
      if (result_q.size() == 0) begin
        $error("unexpected word: value %h error %b", got_word.value, got_word.err);
        fail_cnt++;
      end else begin
        exp_word = result_q.pop_front();
        if (got_word.value !== exp_word.value) begin
          $error("value: expected %h, actual %h", exp_word.value, got_word.value);
          fail_cnt++;
        end
        if (got_word.err !== exp_word.err) begin
          $error("error: expected %b, actual %b", exp_word.err, got_word.err);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("r250_xor_random_generator_core test failed");
    $finish;
  end

  initial begin
    logic [LCG_W-1:0] seed;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: reseed from the reset seed first, so no draw sees an unfilled ring.
    push_req(REQ_RESEED, 16'h0000);
    push_req(REQ_RAW, 16'hFFFF);
    push_req(REQ_RAW, 16'h0000);
    push_req(REQ_BOUNDED, 16'd0);
    push_req(REQ_BOUNDED, 16'd1);
    push_req(REQ_BOUNDED, 16'd65535);
    push_req(REQ_BOUNDED, 16'd32768);
    push_req(REQ_BOUNDED, 16'd32769);
    push_req(REQ_BOUNDED, 16'd2);
    push_req(REQ_UNUSED, 16'hFFFF);
    push_req(REQ_BOUNDED, 16'h5555);
    push_req(REQ_BOUNDED, 16'hAAAA);
    push_req(REQ_UNUSED, 16'h0000);
    push_req(REQ_RAW, 16'h5A5A);
    push_req(REQ_RESEED, 16'hFFFF);
    push_req(REQ_RAW, 16'h0000);
    push_req(REQ_BOUNDED, 16'd3);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       seed = 32'hFFFF_FFFF;
        1:       seed = 32'h0000_0001;
        2:       seed = 32'h8000_0000;
        3:       seed = 32'h0000_0000;
        default: seed = $urandom();
      endcase
      @(posedge clk_i);
      seed_we_i    <= 1'b1;
      seed_wdata_i <= seed;
      @(posedge clk_i);
      seed_we_i <= 1'b0;
      seed_copy = seed;
      // odd phases keep drawing from the old ring before the new seed is used
      if (p % 2 == 0) push_req(REQ_RESEED, WORD_W'($urandom_range(0, 65535)));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) req_q.push_back(pick_req());
      if (p % 2 == 1) push_req(REQ_RESEED, WORD_W'($urandom_range(0, 65535)));
      drain();
    end

    if (fail_cnt == 0) begin
      $display("r250_xor_random_generator_core test passed");
    end else begin
      $display("r250_xor_random_generator_core test failed");
    end
    $finish;
  end

endmodule
